// ----- rtl/cite_pkg.sv -----
// Shared types, constants and the record byte function for the cell id text encoder.
// Used by the parser, the job queue, the byte emitter and the top level.
package cite_pkg;

  localparam int unsigned FieldChars = 16;
  localparam int unsigned CntW       = 5;
  localparam int unsigned IdxW       = 4;

  localparam logic [7:0]      CharEquals = 8'h3d;
  localparam logic [IdxW-1:0] IdxLast    = 4'd11;
  localparam logic [IdxW-1:0] IdxEcgi    = 4'd5;
  localparam logic [3:0]      NibFill    = 4'hf;

  localparam logic RecTai  = 1'b0;
  localparam logic RecEcgi = 1'b1;
  localparam logic StOk    = 1'b0;
  localparam logic StErr   = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_kind;
    logic       status;
    logic       last_of_run;
  } out_word_t;

  // One finished field as handed from the parser to the emitter.
  typedef struct packed {
    logic        err;
    logic [11:0] mcc;
    logic [7:0]  mnc;
    logic [15:0] tac;
    logic [27:0] eci;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.nib = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic out_word_t record_byte(input job_t j, input logic [IdxW-1:0] idx);
    out_word_t w;
    w.record_kind = (idx >= IdxEcgi) ? RecEcgi : RecTai;
    w.status      = StOk;
    w.last_of_run = (idx == IdxLast);
    unique case (idx) inside
      4'd0, 4'd5: w.out_byte = j.mcc[7:0];
      4'd1, 4'd6: w.out_byte = {NibFill, j.mcc[11:8]};
      4'd2, 4'd7: w.out_byte = j.mnc;
      4'd3:       w.out_byte = j.tac[15:8];
      4'd4:       w.out_byte = j.tac[7:0];
      4'd8:       w.out_byte = {4'h0, j.eci[27:24]};
      4'd9:       w.out_byte = j.eci[23:16];
      4'd10:      w.out_byte = j.eci[15:8];
      4'd11:      w.out_byte = j.eci[7:0];
      default:    w.out_byte = 8'h00;
    endcase
    if (j.err) begin
      w.out_byte    = 8'h00;
      w.record_kind = RecTai;
      w.status      = StErr;
      w.last_of_run = 1'b1;
    end
    return w;
  endfunction

endpackage

// ----- rtl/cite_parse.sv -----
// Front end: scans characters for the first '=' and collects MCC, MNC, TAC and ECI.
// Depends on cite_pkg; hands one job per field to the job queue.
module cite_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  cite_pkg::in_word_t in_data,
  output logic             job_push,
  output cite_pkg::job_t   job_data
);
  import cite_pkg::*;

  logic            seen_r, seen_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [11:0]     mcc_r, mcc_nxt;
  logic [7:0]      mnc_r, mnc_nxt;
  logic [15:0]     tac_r, tac_nxt;
  logic [27:0]     eci_r, eci_nxt;
  logic [1:0]      stop_r, stop_nxt;
  logic [3:0]      pos;
  logic [3:0]      bcd;
  hex_t            h;

  assign pos = cnt_r[3:0];
  assign bcd = in_data.char_in[3:0];
  assign h   = hex_decode(in_data.char_in);

  always_comb begin
    seen_nxt = seen_r;
    cnt_nxt  = cnt_r;
    mcc_nxt  = mcc_r;
    mnc_nxt  = mnc_r;
    tac_nxt  = tac_r;
    eci_nxt  = eci_r;
    stop_nxt = stop_r;
    if (!seen_r) begin
      if (in_data.char_in == CharEquals) begin
        seen_nxt = 1'b1;
      end
    end else if (!cnt_r[CntW-1]) begin
      if (pos < 4'd3) begin
        mcc_nxt[pos[1:0]*4 +: 4] = mcc_r[pos[1:0]*4 +: 4] | bcd;
      end else if (pos < 4'd5) begin
        // Position 3 fills the low nibble and position 4 the high one.
        mnc_nxt[{pos[2], 2'b00} +: 4] = mnc_r[{pos[2], 2'b00} +: 4] | bcd;
      end else if (pos < 4'd9) begin
        if (!stop_r[0]) begin
          if (!h.ok) stop_nxt[0] = 1'b1;
          else tac_nxt = {tac_r[11:0], h.nib};
        end
      end else begin
        if (!stop_r[1]) begin
          if (!h.ok) stop_nxt[1] = 1'b1;
          else eci_nxt = {eci_r[23:0], h.nib};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign job_push     = accept && in_data.last_char;
  assign job_data.err = !seen_nxt || (cnt_nxt < CntW'(FieldChars));
  assign job_data.mcc = mcc_nxt;
  assign job_data.mnc = mnc_nxt;
  assign job_data.tac = tac_nxt;
  assign job_data.eci = eci_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || job_push) begin
      seen_r <= 1'b0;
      cnt_r  <= '0;
      mcc_r  <= '0;
      mnc_r  <= '0;
      tac_r  <= '0;
      eci_r  <= '0;
      stop_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
      mcc_r  <= mcc_nxt;
      mnc_r  <= mnc_nxt;
      tac_r  <= tac_nxt;
      eci_r  <= eci_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ----- rtl/cite_jobq.sv -----
// Two-entry queue of parsed fields between the parser and the byte emitter.
// Depends on cite_pkg for the job type.
module cite_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cite_pkg::job_t wr_data,
  output logic           q_full,
  input  logic           q_pop,
  output logic           q_empty,
  output cite_pkg::job_t rd_data
);
  import cite_pkg::*;

  job_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_full   = (cnt_r == 2'd2);
  assign q_empty  = (cnt_r == 2'd0);
  assign do_push  = push && !q_full;
  assign do_pop   = q_pop && !q_empty;
  assign rd_data  = mem_r[rptr_r];
  assign wptr_nxt = wptr_r ^ do_push;
  assign rptr_nxt = rptr_r ^ do_pop;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wr_data;
  end

endmodule

// ----- rtl/cite_emit.sv -----
// Back end: walks the record bytes of the oldest job into an output register.
// Depends on cite_pkg for the job, word and byte selection.
module cite_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cite_pkg::job_t      job,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output cite_pkg::out_word_t out_data
);
  import cite_pkg::*;

  out_word_t       word_r, word_nxt;
  logic            valid_r;
  logic [IdxW-1:0] idx_r;
  logic            load;

  assign load     = !valid_r || pop;
  assign word_nxt = record_byte(job, idx_r);
  assign q_pop    = load && !q_empty && word_nxt.last_of_run;
  assign empty    = !valid_r;
  assign out_data = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= word_nxt.last_of_run ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) word_r <= word_nxt;
  end

endmodule

// ----- rtl/cell_id_text_to_tai_ecgi_core.sv -----
// Top level of the location text to TAI/ECGI encoder: parser, job queue, emitter.
// Depends on cite_pkg and the cite_parse, cite_jobq and cite_emit modules.
//
//   channel   handshake      word
//   input     push / full    in_data  (char_in, last_char)
//   result    empty / pop    out_data (out_byte, record_kind, status, last_of_run)
//
// One character is taken every cycle while full is low.
// A good field gives 12 result words from the emitter's index counter, one per
// cycle while pop is high; a malformed one gives a single word. Up to two parsed
// fields wait in the queue, and full rises only while both entries are occupied.
// Reset is synchronous and clears parser state, queue and output valid flag.
module cell_id_text_to_tai_ecgi_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  cite_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output cite_pkg::out_word_t out_data
);
  import cite_pkg::*;

  logic accept;
  logic job_push;
  job_t job_wr;
  job_t job_rd;
  logic q_empty;
  logic q_pop;

  assign accept = push && !full;

  cite_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_wr)
  );

  cite_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_wr),
    .q_full  (full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .rd_data (job_rd)
  );

  cite_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .job      (job_rd),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
